// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the equalize charge controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/eqc_pkg.sv
// Package: types, widths and constants of the equalize charge controller.
`timescale 1ns / 1ps
`default_nettype none
package eqc_pkg;

   // field widths
   localparam int TIMER_W   = 32;
   localparam int MV_W      = 16;
   localparam int AH_W      = 16;
   localparam int CUR_W     = 16;
   localparam int VOLT_W    = 12;
   localparam int HOURS_W   = 8;
   localparam int SOC_W     = 7;
   localparam int REST_W    = 21;
   localparam int SCALED_W  = AH_W + SOC_W;

   // port widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 96;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // serial divider geometry
   localparam int DIV_W     = 32;
   localparam int DIVISOR_W = 16;

   // constants
   localparam logic [DIVISOR_W-1:0] SEC_PER_HOUR  = 16'd3600;
   localparam logic [DIVISOR_W-1:0] SEC_PER_MIN   = 16'd60;
   localparam logic [TIMER_W-1:0]   CHECK_SPAN    = 32'd900;
   localparam logic [TIMER_W-1:0]   FORCE_SPAN    = 32'd1800;
   localparam logic [CUR_W-1:0]     FORCE_CURRENT = 16'd50;
   localparam logic [MV_W:0]        DROP_LIMIT    = 17'd50;
   localparam logic [SOC_W-1:0]     SOC_CAP       = 7'd98;
   localparam logic [SOC_W-1:0]     SOC_SCALE     = 7'd100;
   localparam logic [VOLT_W-1:0]    V_LITHIUM     = 12'd2600;
   localparam logic [VOLT_W-1:0]    V_LEAD        = 12'd2850;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_EQUAL = 2'd1,
      PH_END   = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_RUN  = 1'b1
   } ctl_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EQUAL_CURRENT   = 3'd0,
      CSR_MAX_CURRENT     = 3'd1,
      CSR_EQUAL_HOURS     = 3'd2,
      CSR_FORCE_EQUAL     = 3'd3,
      CSR_LITHIUM_PROFILE = 3'd4,
      CSR_INITIAL_SOC     = 3'd5,
      CSR_CAPACITY_AH     = 3'd6
   } csr_index_type;

endpackage
`default_nettype wire

// File: hw/rtl/eqc_serial_div.sv
// Restoring bit-serial divider: one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module eqc_serial_div
   import eqc_pkg::*;
#(
   parameter int DIVIDEND_W = DIV_W,
   parameter int DIVR_W     = DIVISOR_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVR_W-1:0]     divisor,
   output logic                       busy,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic [DIVR_W-1:0]          remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVR_W-1:0]     rem_ff, rem_in;
   logic [DIVR_W-1:0]     divr_ff, divr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [DIVR_W:0] trial;
   logic [DIVR_W:0] diff;
   logic            take;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, divr_ff};
      take    = (trial >= {1'b0, divr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      divr_in = divr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         divr_in = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], take};
         rem_in  = take ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      divr_ff <= divr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// File: hw/rtl/equalize_charge_phase_controller_unit.sv
// Top level: equalization charge phase sequencer with serial SOC and time math.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One request word is one timer tick. The sequencer loads the current and
// voltage setpoints and the deadline in the start phase, watches timeout and
// the 15-minute dV/dt check while equalizing, refreshes SOC and remaining
// hours on whole minutes, and pulses restart/idle/clear-force on the ending
// step in forced mode. The response word is registered when the step commits,
// and the next request word can be taken as soon as the response turns valid;
// no word is taken before the last step commits, which waits for a free output:
// three 32-bit bit-serial dividers run side by side (timer
// mod 60, charged share over capacity, time left over 3600 s), one quotient
// bit per cycle, and the step commits when they finish. A finished response
// waits in the output register while the next request word is accepted.
// Configuration writes land at once; write them only while no word is in
// flight. Register indexes: 0 equal_current, 1 max_current, 2 equal_hours,
// 3 force_equal, 4 lithium_profile, 5 initial_soc, 6 capacity_ah; index 7
// is ignored.
module equalize_charge_phase_controller_unit
   import eqc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: restart, now_seconds, cell_millivolts, charged_ah (low to high)
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // response: phase, current_request, cell_voltage_request, phase_deadline,
   // dvdt_fault, start_next, go_idle, clear_force, soc_percent, rest_hours,
   // display_update (low to high)
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // configuration write port
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [CUR_W-1:0]   equal_current_ff;
   logic [CUR_W-1:0]   max_current_ff;
   logic [HOURS_W-1:0] equal_hours_ff;
   logic               force_equal_ff;
   logic               lithium_ff;
   logic [SOC_W-1:0]   initial_soc_ff;
   logic [AH_W-1:0]    capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         equal_current_ff <= '0;
         max_current_ff   <= '0;
         equal_hours_ff   <= '0;
         force_equal_ff   <= 1'b0;
         lithium_ff       <= 1'b0;
         initial_soc_ff   <= '0;
         capacity_ff      <= AH_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_EQUAL_CURRENT:   equal_current_ff <= csr_wdata[CUR_W-1:0];
            CSR_MAX_CURRENT:     max_current_ff   <= csr_wdata[CUR_W-1:0];
            CSR_EQUAL_HOURS:     equal_hours_ff   <= csr_wdata[HOURS_W-1:0];
            CSR_FORCE_EQUAL:     force_equal_ff   <= csr_wdata[0];
            CSR_LITHIUM_PROFILE: lithium_ff       <= csr_wdata[0];
            CSR_INITIAL_SOC:     initial_soc_ff   <= csr_wdata[SOC_W-1:0];
            CSR_CAPACITY_AH:     capacity_ff      <= csr_wdata[AH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request unpack ----------------
   logic               req_restart;
   logic [TIMER_W-1:0] req_now;
   logic [MV_W-1:0]    req_mv;
   logic [AH_W-1:0]    req_ah;
   logic [SCALED_W-1:0] ah_scaled;

   assign req_restart = req_tdata[0];
   assign req_now     = req_tdata[TIMER_W:1];
   assign req_mv      = req_tdata[TIMER_W+MV_W:TIMER_W+1];
   assign req_ah      = req_tdata[TIMER_W+MV_W+AH_W:TIMER_W+MV_W+1];
   assign ah_scaled   = SCALED_W'(req_ah) * SCALED_W'(SOC_SCALE);

   // ---------------- control ----------------
   ctl_type ctl_ff, ctl_in;
   logic    accept;
   logic    commit;
   logic    div_busy;
   logic    rsp_valid_ff, rsp_valid_in;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      ctl_in     = ctl_ff;
      req_tready = 1'b0;
      commit     = 1'b0;
      case (ctl_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) ctl_in = CTL_RUN;
         end
         CTL_RUN: begin
            // commit once all dividers are done and the output slot is free
            if (!div_busy && (!rsp_valid_ff || rsp_tready)) begin
               commit = 1'b1;
               ctl_in = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // latched request word
   logic               restart_ff;
   logic [TIMER_W-1:0] now_ff;
   logic [MV_W-1:0]    mv_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         restart_ff <= req_restart;
         now_ff     <= req_now;
         mv_ff      <= req_mv;
      end
   end

   // ---------------- sequencer state ----------------
   phase_type          phase_ff, phase_in;
   logic [TIMER_W-1:0] deadline_ff, deadline_in;
   logic [TIMER_W-1:0] check_ff, check_in;
   logic [MV_W-1:0]    last_mv_ff, last_mv_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [VOLT_W-1:0]  volt_ff, volt_in;
   logic [SOC_W-1:0]   soc_ff, soc_in;
   logic [REST_W-1:0]  rest_ff, rest_in;

   // ---------------- serial dividers ----------------
   logic                 min_busy, soc_busy, rest_busy;
   logic [DIV_W-1:0]     min_quo, soc_quo, rest_quo;
   logic [DIVISOR_W-1:0] min_rem, soc_rem, rest_rem;

   // now mod 60
   eqc_serial_div #(
      .DIVIDEND_W (DIV_W),
      .DIVR_W     (DIVISOR_W)
   ) u_min_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_now),
      .divisor   (SEC_PER_MIN),
      .busy      (min_busy),
      .quotient  (min_quo),
      .remainder (min_rem)
   );

   // charged_ah * 100 / capacity
   eqc_serial_div #(
      .DIVIDEND_W (DIV_W),
      .DIVR_W     (DIVISOR_W)
   ) u_soc_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (DIV_W'(ah_scaled)),
      .divisor   (DIVISOR_W'(capacity_ff)),
      .busy      (soc_busy),
      .quotient  (soc_quo),
      .remainder (soc_rem)
   );

   // (deadline - now) / 3600; used only when the deadline is ahead
   eqc_serial_div #(
      .DIVIDEND_W (DIV_W),
      .DIVR_W     (DIVISOR_W)
   ) u_rest_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (deadline_ff - req_now),
      .divisor   (SEC_PER_HOUR),
      .busy      (rest_busy),
      .quotient  (rest_quo),
      .remainder (rest_rem)
   );

   assign div_busy = min_busy || soc_busy || rest_busy;

   // ---------------- step logic ----------------
   phase_type          phase_now;
   logic [CUR_W-1:0]   cur_capped;
   logic [19:0]        hour_span;
   logic [MV_W:0]      drop;
   logic [DIV_W:0]     soc_sum;
   logic               on_minute;
   logic               fault;
   logic               pulse;
   logic               refresh;

   always_comb begin
      phase_now   = restart_ff ? PH_START : phase_ff;
      cur_capped  = (equal_current_ff > max_current_ff) ? max_current_ff
                                                        : equal_current_ff;
      hour_span   = 20'(equal_hours_ff) * 20'(SEC_PER_HOUR);
      drop        = {1'b0, last_mv_ff} - {1'b0, mv_ff};
      soc_sum     = (DIV_W+1)'(soc_quo) + (DIV_W+1)'(initial_soc_ff);
      on_minute   = (min_rem == '0);

      phase_in    = phase_now;
      deadline_in = deadline_ff;
      check_in    = check_ff;
      last_mv_in  = last_mv_ff;
      cur_in      = cur_ff;
      volt_in     = volt_ff;
      soc_in      = soc_ff;
      rest_in     = rest_ff;
      fault       = 1'b0;
      pulse       = 1'b0;
      refresh     = 1'b0;

      case (phase_now)
         PH_START: begin
            if (force_equal_ff) begin
               deadline_in = now_ff + FORCE_SPAN;
               cur_in      = FORCE_CURRENT;
            end else begin
               deadline_in = now_ff + TIMER_W'(hour_span);
               cur_in      = cur_capped;
            end
            last_mv_in = '0;
            check_in   = now_ff + CHECK_SPAN;
            volt_in    = lithium_ff ? V_LITHIUM : V_LEAD;
            phase_in   = PH_EQUAL;
         end
         PH_EQUAL: begin
            if (now_ff > deadline_ff) begin
               phase_in = PH_END;
            end else if (now_ff >= check_ff) begin
               // dV/dt check: fault on a drop of more than the limit
               if ((last_mv_ff > mv_ff) && (drop > DROP_LIMIT)) begin
                  fault    = 1'b1;
                  phase_in = PH_END;
               end
               last_mv_in = mv_ff;
               check_in   = now_ff + CHECK_SPAN;
            end
            if (on_minute) begin
               if (capacity_ff == '0)
                  soc_in = SOC_CAP;
               else if (soc_sum > (DIV_W+1)'(SOC_CAP))
                  soc_in = SOC_CAP;
               else
                  soc_in = soc_sum[SOC_W-1:0];
               if (deadline_ff > now_ff)
                  rest_in = rest_quo[REST_W-1:0] + REST_W'(1);
               else
                  rest_in = REST_W'(1);
               refresh = 1'b1;
            end
         end
         PH_END: begin
            pulse    = force_equal_ff;
            phase_in = PH_DONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         deadline_ff <= '0;
         check_ff    <= '0;
         last_mv_ff  <= '0;
         cur_ff      <= '0;
         volt_ff     <= '0;
         soc_ff      <= '0;
         rest_ff     <= '0;
      end else if (commit) begin
         phase_ff    <= phase_in;
         deadline_ff <= deadline_in;
         check_ff    <= check_in;
         last_mv_ff  <= last_mv_in;
         cur_ff      <= cur_in;
         volt_ff     <= volt_in;
         soc_ff      <= soc_in;
         rest_ff     <= rest_in;
      end
   end

   // ---------------- response register ----------------
   logic [RSP_TDATA_W-1:0] rsp_word;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign rsp_word = RSP_TDATA_W'({refresh, rest_in, soc_in, pulse, pulse, pulse, fault,
                                   deadline_in, volt_in, cur_in, phase_in});

   always_ff @(posedge clock) begin
      if (commit) rsp_data_ff <= rsp_word;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   // no divider may still run while a new word can be accepted
   `ASSERT_IMPLY(a_idle_div_done, clock, reset, ctl_ff == CTL_IDLE, !div_busy)
   // every committed step leaves the start phase behind
   `ASSERT_NEXT(a_commit_leaves_start, clock, reset, commit, phase_ff != PH_START)
   // a dV/dt fault always comes with the ending phase
   `ASSERT_IMPLY(a_fault_ends, clock, reset, rsp_tvalid && rsp_tdata[62],
                 rsp_tdata[1:0] == PH_END)
   // end-of-charge pulses only on the step that finishes
   `ASSERT_IMPLY(a_pulse_done, clock, reset, commit && pulse, phase_in == PH_DONE)

endmodule
`default_nettype wire
